>>> src/euler_world_to_body_transform_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the euler world-to-body transform
// Shared clocking and reset handling for the concurrent checks.
// ---------------------------------------------------------------------------
`ifndef EULER_WORLD_TO_BODY_TRANSFORM_DEFINES_SVH
`define EULER_WORLD_TO_BODY_TRANSFORM_DEFINES_SVH

// check that is switched off while reset is asserted
`define EWB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check that also holds during reset
`define EWB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/ewb_pkg.sv
// ---------------------------------------------------------------------------
// ewb_pkg
// Constants and rounding helpers for the euler world-to-body transform.
// ---------------------------------------------------------------------------
package ewb_pkg;

	localparam int ANGLE_BITS_DEF = 16;
	localparam int POS_BITS_DEF   = 20;
	localparam int OUT_BITS       = 22;

	// quarter-sine polynomial, Q15
	localparam logic [15:0] POLY_A   = 16'd51472;
	localparam logic [14:0] POLY_B   = 15'd21024;
	localparam logic [11:0] POLY_C   = 12'd2320;
	localparam logic [15:0] TRIG_ONE = 16'd32768;

	// axis component width (Q15, signed, with headroom)
	localparam int COMP_W = 19;

	typedef logic signed [16:0] trig_t;
	typedef logic signed [33:0] pair_t;
	typedef logic signed [50:0] triple_t;
	typedef logic signed [COMP_W-1:0] comp_t;

	// round half up by 15 bits
	function automatic comp_t rnd15(input logic signed [34:0] v);
		logic signed [34:0] t;
		t = v + 35'sd16384;
		return comp_t'(t >>> 15);
	endfunction

	// round half up by 30 bits
	function automatic comp_t rnd30(input logic signed [53:0] v);
		logic signed [53:0] t;
		t = v + (54'sd1 <<< 29);
		return comp_t'(t >>> 30);
	endfunction

endpackage

>>> src/ewb_qsine.sv
// ---------------------------------------------------------------------------
// ewb_qsine
// Four-stage quarter-wave sine, S(z) = z*(A - z2*(B - z2*C)), Q15 in and out.
// ---------------------------------------------------------------------------
module ewb_qsine (
	input  logic        clk,
	input  logic [3:0]  en,      // stage enables, lowest bit first stage
	input  logic [15:0] z,       // 0..32768
	output logic [15:0] q        // 0..32768
);
	import ewb_pkg::*;

	logic [15:0] z_a, z_b, z_c;
	logic [16:0] z2_a, z2_b;
	logic [14:0] inner_b;
	logic [15:0] p_c;
	logic [31:0] zz, cz, iz, pz;

	assign zz = 32'(z) * 32'(z);
	assign cz = 32'(z2_a) * 32'(POLY_C);
	assign iz = 32'(z2_b) * 32'(inner_b);
	assign pz = 32'(z_c) * 32'(p_c);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			z_a  <= z;
			z2_a <= zz[31:15];
		end
		if (en[1]) begin
			z_b     <= z_a;
			z2_b    <= z2_a;
			inner_b <= POLY_B - cz[29:15];
		end
		if (en[2]) begin
			z_c <= z_b;
			p_c <= POLY_A - iz[30:15];
		end
		if (en[3]) begin
			q <= pz[30:15];
		end
	end

endmodule

>>> src/euler_world_to_body_transform.sv
// ---------------------------------------------------------------------------
// euler_world_to_body_transform
// Projects a target offset onto a body's forward, right and up axes.
// ---------------------------------------------------------------------------
// Takes pitch, yaw and roll (binary angles, half scale = pi) plus body and
// target positions (Q.4) and returns the target offset in body axes,
// Q17.4, saturated to 22 bits. Fully pipelined over 11 register stages:
// one transaction in per cycle while the output side is not stalling. Each
// stage holds its own valid bit and only stalls when the stage after it is
// full and stalled, so bubbles are squeezed out and a waiting result stops
// new input only once every stage ahead of it is full. The stage count is
// set by the quarter-sine polynomial (four dependent multiplies) followed
// by the triple angle products and the projection multiply-accumulate.
// No state is kept between transactions.
// ---------------------------------------------------------------------------
module euler_world_to_body_transform #(
	parameter int ANGLE_BITS = ewb_pkg::ANGLE_BITS_DEF,
	parameter int POS_BITS   = ewb_pkg::POS_BITS_DEF,
	localparam int IN_W  = ((3*ANGLE_BITS + 6*POS_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((3*ewb_pkg::OUT_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// pitch_angle, yaw_angle, roll_angle, body_x, body_y, body_z,
	// target_x, target_y, target_z, zero pad
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// local_forward, local_right, local_up, zero pad
	output logic [OUT_W-1:0] m_tdata
);
	import ewb_pkg::*;

	localparam int NS   = 11;            // pipeline stages
	localparam int DW   = POS_BITS + 1;  // offset width
	localparam int PW   = DW + COMP_W;   // projection product width
	localparam int AW   = PW + 2;        // accumulator width
	localparam int RAW_W = OUT_BITS * 3;

	localparam logic signed [AW-1:0] SAT_HI = AW'((64'sd1 <<< (OUT_BITS-1)) - 1);
	localparam logic signed [AW-1:0] SAT_LO = AW'(-(64'sd1 <<< (OUT_BITS-1)));

	// ---- stage control: a stage moves when it is empty or the next moves
	logic [NS:1]   v_q;
	logic [NS+1:1] en;

	assign en[NS+1] = m_tready;
	for (genvar k = 1; k <= NS; k++) begin : g_en
		assign en[k] = !v_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[1]) v_q[1] <= s_tvalid;
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	assign s_tready = en[1];
	assign m_tvalid = v_q[NS];

	// ---- stage 1: quadrant, quarter-turn fraction, offsets
	logic [1:0]  quad_s1 [3];
	logic [15:0] z_s1    [6];   // even: z, odd: 1 - z
	logic signed [DW-1:0] d_s1 [3];

	for (genvar i = 0; i < 3; i++) begin : g_ang
		logic [ANGLE_BITS-1:0] ang;
		logic [ANGLE_BITS+12:0] zx;
		logic [15:0] zz;
		logic [POS_BITS-1:0] bp, tp;

		assign ang = s_tdata[i*ANGLE_BITS +: ANGLE_BITS];
		assign zx  = {ang[ANGLE_BITS-3:0], 15'b0} >> (ANGLE_BITS - 2);
		assign zz  = {1'b0, zx[14:0]};
		assign bp  = s_tdata[3*ANGLE_BITS + i*POS_BITS +: POS_BITS];
		assign tp  = s_tdata[3*ANGLE_BITS + (i+3)*POS_BITS +: POS_BITS];

		always_ff @(posedge clk) begin
			if (en[1]) begin
				quad_s1[i]     <= ang[ANGLE_BITS-1 -: 2];
				z_s1[2*i]      <= zz;
				z_s1[2*i+1]    <= TRIG_ONE - zz;
				d_s1[i]        <= $signed({tp[POS_BITS-1], tp}) - $signed({bp[POS_BITS-1], bp});
			end
		end
	end

	// ---- stages 2..5: six quarter-sine pipelines; quadrant and offset ride along
	logic [15:0] qs_s5 [6];
	logic [1:0]  quad_p [2:5][3];
	logic signed [DW-1:0] d_p [2:9][3];

	for (genvar j = 0; j < 6; j++) begin : g_sin
		ewb_qsine u_qsine (
			.clk (clk),
			.en  (en[5:2]),
			.z   (z_s1[j]),
			.q   (qs_s5[j])
		);
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			quad_p[2] <= quad_s1;
			d_p[2]    <= d_s1;
		end
		for (int k = 3; k <= 5; k++) begin
			if (en[k]) quad_p[k] <= quad_p[k-1];
		end
		for (int k = 3; k <= 9; k++) begin
			if (en[k]) d_p[k] <= d_p[k-1];
		end
	end

	// ---- stage 6: sine and cosine by quadrant
	trig_t sn_s6 [3];
	trig_t cs_s6 [3];

	always_ff @(posedge clk) begin
		if (en[6]) begin
			for (int i = 0; i < 3; i++) begin
				unique case (quad_p[5][i])
					2'd0: begin
						sn_s6[i] <= $signed({1'b0, qs_s5[2*i]});
						cs_s6[i] <= $signed({1'b0, qs_s5[2*i+1]});
					end
					2'd1: begin
						sn_s6[i] <= $signed({1'b0, qs_s5[2*i+1]});
						cs_s6[i] <= -$signed({1'b0, qs_s5[2*i]});
					end
					2'd2: begin
						sn_s6[i] <= -$signed({1'b0, qs_s5[2*i]});
						cs_s6[i] <= -$signed({1'b0, qs_s5[2*i+1]});
					end
					default: begin
						sn_s6[i] <= -$signed({1'b0, qs_s5[2*i+1]});
						cs_s6[i] <= $signed({1'b0, qs_s5[2*i]});
					end
				endcase
			end
		end
	end

	// ---- stage 7: pair products (p = pitch 0, y = yaw 1, r = roll 2)
	pair_t cpcy_s7, cpsy_s7, cysp_s7, crsy_s7, sysp_s7, crcy_s7;
	pair_t srsy_s7, srcy_s7, cpsr_s7, cpcr_s7;
	trig_t sp_s7, sr_s7;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			cpcy_s7 <= cs_s6[0] * cs_s6[1];
			cpsy_s7 <= cs_s6[0] * sn_s6[1];
			cysp_s7 <= cs_s6[1] * sn_s6[0];
			crsy_s7 <= cs_s6[2] * sn_s6[1];
			sysp_s7 <= sn_s6[1] * sn_s6[0];
			crcy_s7 <= cs_s6[2] * cs_s6[1];
			srsy_s7 <= sn_s6[2] * sn_s6[1];
			srcy_s7 <= sn_s6[2] * cs_s6[1];
			cpsr_s7 <= cs_s6[0] * sn_s6[2];
			cpcr_s7 <= cs_s6[0] * cs_s6[2];
			sp_s7   <= sn_s6[0];
			sr_s7   <= sn_s6[2];
		end
	end

	// ---- stage 8: triple products
	triple_t cyspsr_s8, syspsr_s8, crcysp_s8, crsysp_s8;
	pair_t   cpcy_s8, cpsy_s8, crsy_s8, crcy_s8, srsy_s8, srcy_s8, cpsr_s8, cpcr_s8;
	trig_t   sp_s8;

	always_ff @(posedge clk) begin
		if (en[8]) begin
			cyspsr_s8 <= cysp_s7 * sr_s7;
			syspsr_s8 <= sysp_s7 * sr_s7;
			crcysp_s8 <= crcy_s7 * sp_s7;
			crsysp_s8 <= crsy_s7 * sp_s7;
			cpcy_s8   <= cpcy_s7;
			cpsy_s8   <= cpsy_s7;
			crsy_s8   <= crsy_s7;
			crcy_s8   <= crcy_s7;
			srsy_s8   <= srsy_s7;
			srcy_s8   <= srcy_s7;
			cpsr_s8   <= cpsr_s7;
			cpcr_s8   <= cpcr_s7;
			sp_s8     <= sp_s7;
		end
	end

	// ---- stage 9: axis components, Q30 products and Q45 sums rounded to Q15
	comp_t ax_s9 [3][3];   // [axis][xyz], axis 0 fwd, 1 right, 2 up

	always_ff @(posedge clk) begin
		if (en[9]) begin
			ax_s9[0][0] <= rnd15(35'(cpcy_s8));
			ax_s9[0][1] <= rnd15(35'(cpsy_s8));
			ax_s9[0][2] <= COMP_W'(sp_s8);
			ax_s9[1][0] <= rnd30(54'(cyspsr_s8) - (54'(crsy_s8) <<< 15));
			ax_s9[1][1] <= rnd30(54'(syspsr_s8) + (54'(crcy_s8) <<< 15));
			ax_s9[1][2] <= rnd15(-35'(cpsr_s8));
			ax_s9[2][0] <= rnd30(-54'(crcysp_s8) - (54'(srsy_s8) <<< 15));
			ax_s9[2][1] <= rnd30(-54'(crsysp_s8) + (54'(srcy_s8) <<< 15));
			ax_s9[2][2] <= rnd15(35'(cpcr_s8));
		end
	end

	// ---- stage 10: offset times component
	logic signed [PW-1:0] prod_s10 [3][3];

	always_ff @(posedge clk) begin
		if (en[10]) begin
			for (int a = 0; a < 3; a++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s10[a][k] <= PW'(d_p[9][k]) * PW'(ax_s9[a][k]);
				end
			end
		end
	end

	// ---- stage 11: sum, round to Q.4, saturate; this is the output register
	logic [OUT_BITS-1:0] res [3];
	logic [RAW_W-1:0]    out_s11;

	always_comb begin
		logic signed [AW-1:0] acc;
		logic signed [AW-1:0] r;
		for (int a = 0; a < 3; a++) begin
			acc = AW'(prod_s10[a][0]) + AW'(prod_s10[a][1]) + AW'(prod_s10[a][2])
				+ AW'(16384);
			r = acc >>> 15;
			priority if (r > SAT_HI) begin
				res[a] = SAT_HI[OUT_BITS-1:0];
			end else if (r < SAT_LO) begin
				res[a] = SAT_LO[OUT_BITS-1:0];
			end else begin
				res[a] = r[OUT_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[11]) begin
			out_s11 <= {res[2], res[1], res[0]};
		end
	end

	assign m_tdata = OUT_W'(out_s11);

endmodule

>>> src/ewb_checker.sv
// ---------------------------------------------------------------------------
// ewb_checker
// Port-level checks on the euler world-to-body transform, bound to the top.
// ---------------------------------------------------------------------------
`include "euler_world_to_body_transform_defines.svh"

module ewb_checker #(
	parameter int OUT_W = 72
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	// output held while stalled
	`EWB_ASSERT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "output transaction dropped")
	`EWB_ASSERT(a_hold_data, m_tvalid && !m_tready |=> $stable(m_tdata), "stalled data changed")
	// empty output stage means the whole pipe can move
	`EWB_ASSERT(a_ready_when_empty, !m_tvalid |-> s_tready, "input stalled with empty output")
	// a draining output stage lets the whole pipe move
	`EWB_ASSERT(a_ready_on_drain, m_tvalid && m_tready |-> s_tready, "input stalled on drain")
	// nothing comes out after a reset edge
	`EWB_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !m_tvalid, "output valid in reset")

endmodule

bind euler_world_to_body_transform ewb_checker #(.OUT_W(OUT_W)) u_ewb_checker (.*);
